[design/tlbpt_pkg.sv]
// Shared constants, types and command codes of the TLB and page table translator.
package tlbpt_pkg;

    // Sizes of the stores; all counts are powers of two.
    localparam int TLB_ENTRIES = 32;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 128;
    localparam int STAMP_BITS  = 32;

    // Fixed field widths of the transactions.
    localparam int VA_W          = 16;
    localparam int OFFSET_W      = 8;
    localparam int PAGE_FIELD_W  = 8;
    localparam int FRAME_FIELD_W = 7;
    localparam int PA_W          = 15;
    localparam int CNT_W         = 32;

    // Derived widths.
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int TLB_CNT_W   = $clog2(TLB_ENTRIES + 1);
    localparam int FRAME_CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int SCAN_MAX    = (PAGE_COUNT > TLB_ENTRIES) ? PAGE_COUNT : TLB_ENTRIES;
    localparam int SCAN_W      = $clog2(SCAN_MAX + 1);

    // Outcome codes of a translation.
    typedef enum logic [1:0] {
        OUT_TLB_HIT = 2'd0,
        OUT_PT_HIT  = 2'd1,
        OUT_FAULT   = 2'd2
    } outcome_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_TLB_SCAN,
        OP_HIT_COMMIT,
        OP_PT_READ,
        OP_PT_CHECK,
        OP_PT_SCAN,
        OP_LRU_PICK,
        OP_OWNER_READ,
        OP_OWNER_PT_READ,
        OP_EVICT_CHECK,
        OP_INV_SCAN,
        OP_MISS_COMMIT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic tlb_hit;
        logic pt_hit;
        logic frames_full;
        logic lru;
        logic evict;
        logic out_free;
    } dp_status_t;

    // Memory words.
    typedef struct packed {
        logic [PAGE_W-1:0]     page;
        logic [FRAME_W-1:0]    frame;
        logic [STAMP_BITS-1:0] stamp;
    } tlb_entry_t;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame;
        logic [STAMP_BITS-1:0] stamp;
    } pt_entry_t;

endpackage

[design/tlbpt_if.sv]
// Valid/ready channel interfaces for address requests and translation results.
interface tlbpt_in_if;
    import tlbpt_pkg::*;

    logic            valid;
    logic            ready;
    logic [VA_W-1:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if;
    import tlbpt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PAGE_FIELD_W-1:0]  virt_page;
    logic [FRAME_FIELD_W-1:0] frame_number;
    logic [PA_W-1:0]          physical_address;
    logic [1:0]               outcome;
    logic                     evicted_valid;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
    logic [CNT_W-1:0]         hit_total;
    logic [CNT_W-1:0]         fault_total;

    modport source (
        output valid, output virt_page, output frame_number, output physical_address,
        output outcome, output evicted_valid, output evicted_page, output hit_total,
        output fault_total, input ready
    );
    modport sink (
        input valid, input virt_page, input frame_number, input physical_address,
        input outcome, input evicted_valid, input evicted_page, input hit_total,
        input fault_total, output ready
    );
endinterface

[design/tlb_page_table_translator_core.sv]
// Top level of the address translator: controller, datapath and channel wiring.
//
// Translates a 16-bit virtual address (page in the upper byte, offset in the lower byte)
// through a 32-entry fully associative TLB and a 256-entry page table, assigning a
// physical frame on a page fault: free frames in order first, then FIFO round robin or
// the least recently used valid page, as set by the replace_lru register. One
// transaction is handled at a time. The TLB memory is searched one entry per cycle;
// a page table hit or a fault that evicts nothing then adds a page table read and check.
// A fault that evicts needs an owner lookup and a second TLB pass to drop the evicted
// page's entries, and an LRU eviction adds a pass over the page table memory of one
// entry per cycle. A result held by a stalled sink delays the end of the next
// transaction. The result register lets a finished result wait while the next request
// is accepted. replace_lru is written through cfg_wr_en and cfg_wr_data and must only
// change while no request is in flight.
module tlb_page_table_translator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    tlbpt_in_if.sink    in_ch,
    tlbpt_out_if.source out_ch
);
    import tlbpt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    tlbpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, scans and result register.
    tlbpt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_va       (in_ch.virtual_address),
        .cmd         (cmd),
        .status      (status),
        .out_ch      (out_ch)
    );

endmodule

[design/tlbpt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tlbpt_ctrl.sv]
// Controller state machine that sequences lookup, replacement and result delivery.
module tlbpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlbpt_pkg::dp_status_t status,
    output tlbpt_pkg::dp_cmd_t    cmd
);
    import tlbpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TLB_SCAN,
        S_HIT,
        S_PT_READ,
        S_PT_CHECK,
        S_PT_SCAN,
        S_LRU_PICK,
        S_OWNER_READ,
        S_OWNER_PT,
        S_EVICT_CHECK,
        S_INV_SCAN,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and the datapath operation of the current state.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_TLB_SCAN;
                end
            end
            S_TLB_SCAN:
            begin
                cmd.op = OP_TLB_SCAN;
                if (status.scan_done)
                begin
                    state_next = status.tlb_hit ? S_HIT : S_PT_READ;
                end
            end
            S_HIT:
            begin
                cmd.op     = OP_HIT_COMMIT;
                state_next = S_FINISH;
            end
            S_PT_READ:
            begin
                cmd.op     = OP_PT_READ;
                state_next = S_PT_CHECK;
            end
            S_PT_CHECK:
            begin
                cmd.op = OP_PT_CHECK;
                priority if (status.pt_hit || !status.frames_full)
                begin
                    state_next = S_COMMIT;
                end
                else if (status.lru)
                begin
                    state_next = S_PT_SCAN;
                end
                else
                begin
                    state_next = S_OWNER_READ;
                end
            end
            S_PT_SCAN:
            begin
                cmd.op = OP_PT_SCAN;
                if (status.scan_done)
                begin
                    state_next = S_LRU_PICK;
                end
            end
            S_LRU_PICK:
            begin
                cmd.op     = OP_LRU_PICK;
                state_next = S_OWNER_READ;
            end
            S_OWNER_READ:
            begin
                cmd.op     = OP_OWNER_READ;
                state_next = S_OWNER_PT;
            end
            S_OWNER_PT:
            begin
                cmd.op     = OP_OWNER_PT_READ;
                state_next = S_EVICT_CHECK;
            end
            S_EVICT_CHECK:
            begin
                cmd.op     = OP_EVICT_CHECK;
                state_next = status.evict ? S_INV_SCAN : S_COMMIT;
            end
            S_INV_SCAN:
            begin
                cmd.op = OP_INV_SCAN;
                if (status.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_MISS_COMMIT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op = OP_FINISH;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/tlbpt_dp.sv]
// Datapath: TLB, page table and frame owner memories, scans, counters and result register.
module tlbpt_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic [tlbpt_pkg::VA_W-1:0] in_va,
    input  tlbpt_pkg::dp_cmd_t        cmd,
    output tlbpt_pkg::dp_status_t     status,
    tlbpt_out_if.source               out_ch
);
    import tlbpt_pkg::*;

    // Control state.
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    logic [PAGE_COUNT-1:0]  pt_valid_reg, pt_valid_next;
    logic [TLB_IDX_W-1:0]   tlb_next_reg, tlb_next_next;
    logic [TLB_CNT_W-1:0]   tlb_filled_reg, tlb_filled_next;
    logic [FRAME_W-1:0]     frame_next_reg, frame_next_next;
    logic [FRAME_CNT_W-1:0] frames_filled_reg, frames_filled_next;
    logic [STAMP_BITS-1:0]  time_reg, time_next;
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       fault_cnt_reg, fault_cnt_next;
    logic                   lru_reg, lru_next;
    logic [SCAN_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   out_valid_reg, out_valid_next;

    // Per-transaction working registers.
    logic [SCAN_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    outcome_t              outcome_reg, outcome_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [PAGE_W-1:0]     ev_page_reg, ev_page_next;
    logic                  hit_found_reg, hit_found_next;
    logic [TLB_IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [FRAME_W-1:0]    hit_frame_reg, hit_frame_next;
    logic [STAMP_BITS-1:0] min_stamp_reg, min_stamp_next;
    logic [TLB_IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic                  inv_found_reg, inv_found_next;
    logic [TLB_IDX_W-1:0]  inv_idx_reg, inv_idx_next;
    logic                  best_any_reg, best_any_next;
    logic [STAMP_BITS-1:0] best_stamp_reg, best_stamp_next;
    logic [FRAME_W-1:0]    best_frame_reg, best_frame_next;
    logic [PAGE_W-1:0]     owner_reg, owner_next;

    // Result register.
    logic [PAGE_FIELD_W-1:0]  o_page_reg, o_page_next;
    logic [FRAME_FIELD_W-1:0] o_frame_reg, o_frame_next;
    logic [PA_W-1:0]          o_pa_reg, o_pa_next;
    logic [1:0]               o_outcome_reg, o_outcome_next;
    logic                     o_ev_valid_reg, o_ev_valid_next;
    logic [PAGE_FIELD_W-1:0]  o_ev_page_reg, o_ev_page_next;
    logic [CNT_W-1:0]         o_hits_reg, o_hits_next;
    logic [CNT_W-1:0]         o_faults_reg, o_faults_next;

    // Memory ports.
    logic                 tlb_we;
    logic [TLB_IDX_W-1:0] tlb_waddr;
    tlb_entry_t           tlb_wdata;
    tlb_entry_t           tlb_rdata;
    logic                 pt_we;
    pt_entry_t            pt_wdata;
    logic [PAGE_W-1:0]    pt_raddr;
    pt_entry_t            pt_rdata;
    logic                 own_we;
    logic [PAGE_W-1:0]    own_rdata;

    // Scan helpers.
    logic                 scan_op;
    logic [SCAN_W-1:0]    scan_limit;
    logic [TLB_IDX_W-1:0] cmp_tlb_idx;
    logic [PAGE_W-1:0]    cmp_pt_idx;
    logic                 out_free;
    logic                 evict;
    logic                 inv_match;
    logic [TLB_IDX_W-1:0] slot;

    tlbpt_ram #(.WIDTH($bits(tlb_entry_t)), .DEPTH(TLB_ENTRIES)) u_tlb_ram (
        .clk     (clk),
        .wr_en   (tlb_we),
        .wr_addr (tlb_waddr),
        .wr_data (tlb_wdata),
        .rd_addr (scan_idx_reg[TLB_IDX_W-1:0]),
        .rd_data (tlb_rdata)
    );

    tlbpt_ram #(.WIDTH($bits(pt_entry_t)), .DEPTH(PAGE_COUNT)) u_pt_ram (
        .clk     (clk),
        .wr_en   (pt_we),
        .wr_addr (page_reg),
        .wr_data (pt_wdata),
        .rd_addr (pt_raddr),
        .rd_data (pt_rdata)
    );

    tlbpt_ram #(.WIDTH(PAGE_W), .DEPTH(FRAME_COUNT)) u_owner_ram (
        .clk     (clk),
        .wr_en   (own_we),
        .wr_addr (frame_reg),
        .wr_data (page_reg),
        .rd_addr (frame_reg),
        .rd_data (own_rdata)
    );

    // Status toward the controller.
    assign scan_op     = (cmd.op == OP_TLB_SCAN) || (cmd.op == OP_PT_SCAN)
                      || (cmd.op == OP_INV_SCAN);
    assign scan_limit  = (cmd.op == OP_PT_SCAN) ? SCAN_W'(PAGE_COUNT) : SCAN_W'(TLB_ENTRIES);
    assign cmp_tlb_idx = cmp_idx_reg[TLB_IDX_W-1:0];
    assign cmp_pt_idx  = cmp_idx_reg[PAGE_W-1:0];
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign evict       = pt_valid_reg[owner_reg] && (pt_rdata.frame == frame_reg);
    assign inv_match   = tlb_valid_reg[cmp_tlb_idx] && (tlb_rdata.page == owner_reg);

    assign status.scan_done   = (scan_idx_reg == scan_limit) && !cmp_valid_reg;
    assign status.tlb_hit     = hit_found_reg;
    assign status.pt_hit      = pt_valid_reg[page_reg];
    assign status.frames_full = (frames_filled_reg == FRAME_CNT_W'(FRAME_COUNT));
    assign status.lru         = lru_reg;
    assign status.evict       = evict;
    assign status.out_free    = out_free;

    // TLB slot for an insertion: in order while filling or under FIFO, else the
    // first free slot, else the oldest stamp.
    always_comb
    begin
        priority if ((tlb_filled_reg < TLB_CNT_W'(TLB_ENTRIES)) || !lru_reg)
        begin
            slot = tlb_next_reg;
        end
        else if (inv_found_reg)
        begin
            slot = inv_idx_reg;
        end
        else
        begin
            slot = min_idx_reg;
        end
    end

    // Operation decode and next-state logic.
    always_comb
    begin
        tlb_valid_next     = tlb_valid_reg;
        pt_valid_next      = pt_valid_reg;
        tlb_next_next      = tlb_next_reg;
        tlb_filled_next    = tlb_filled_reg;
        frame_next_next    = frame_next_reg;
        frames_filled_next = frames_filled_reg;
        time_next          = time_reg;
        hit_cnt_next       = hit_cnt_reg;
        fault_cnt_next     = fault_cnt_reg;
        lru_next           = cfg_wr_en ? cfg_wr_data : lru_reg;
        scan_idx_next      = scan_idx_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = scan_idx_reg;
        out_valid_next     = out_valid_reg;
        page_next          = page_reg;
        offset_next        = offset_reg;
        frame_next         = frame_reg;
        outcome_next       = outcome_reg;
        ev_valid_next      = ev_valid_reg;
        ev_page_next       = ev_page_reg;
        hit_found_next     = hit_found_reg;
        hit_idx_next       = hit_idx_reg;
        hit_frame_next     = hit_frame_reg;
        min_stamp_next     = min_stamp_reg;
        min_idx_next       = min_idx_reg;
        inv_found_next     = inv_found_reg;
        inv_idx_next       = inv_idx_reg;
        best_any_next      = best_any_reg;
        best_stamp_next    = best_stamp_reg;
        best_frame_next    = best_frame_reg;
        owner_next         = owner_reg;
        o_page_next        = o_page_reg;
        o_frame_next       = o_frame_reg;
        o_pa_next          = o_pa_reg;
        o_outcome_next     = o_outcome_reg;
        o_ev_valid_next    = o_ev_valid_reg;
        o_ev_page_next     = o_ev_page_reg;
        o_hits_next        = o_hits_reg;
        o_faults_next      = o_faults_reg;
        tlb_we             = 1'b0;
        tlb_waddr          = hit_idx_reg;
        tlb_wdata          = '{page: page_reg, frame: hit_frame_reg, stamp: time_reg};
        pt_we              = 1'b0;
        pt_wdata           = '{frame: frame_reg, stamp: time_reg};
        pt_raddr           = scan_idx_reg[PAGE_W-1:0];
        own_we             = 1'b0;

        // The result register empties when the sink takes the transaction.
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Scan address issue; the read data returns in the cycle after.
        if (scan_op && (scan_idx_reg != scan_limit))
        begin
            scan_idx_next  = scan_idx_reg + 1'b1;
            cmp_valid_next = 1'b1;
        end

        unique case (cmd.op)
            OP_ACCEPT:
            begin
                page_next      = in_va[OFFSET_W +: PAGE_W];
                offset_next    = in_va[OFFSET_W-1:0];
                ev_valid_next  = 1'b0;
                ev_page_next   = '0;
                hit_found_next = 1'b0;
                inv_found_next = 1'b0;
                scan_idx_next  = '0;
            end
            OP_TLB_SCAN:
            begin
                // First matching entry, first free slot and oldest stamp.
                if (cmp_valid_reg)
                begin
                    if (!hit_found_reg && tlb_valid_reg[cmp_tlb_idx]
                        && (tlb_rdata.page == page_reg))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = cmp_tlb_idx;
                        hit_frame_next = tlb_rdata.frame;
                    end
                    if (!inv_found_reg && !tlb_valid_reg[cmp_tlb_idx])
                    begin
                        inv_found_next = 1'b1;
                        inv_idx_next   = cmp_tlb_idx;
                    end
                    if ((cmp_tlb_idx == '0) || (tlb_rdata.stamp < min_stamp_reg))
                    begin
                        min_stamp_next = tlb_rdata.stamp;
                        min_idx_next   = cmp_tlb_idx;
                    end
                end
            end
            OP_HIT_COMMIT:
            begin
                tlb_we       = 1'b1;
                pt_we        = 1'b1;
                pt_wdata     = '{frame: hit_frame_reg, stamp: time_reg};
                frame_next   = hit_frame_reg;
                outcome_next = OUT_TLB_HIT;
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            OP_PT_READ:
            begin
                pt_raddr = page_reg;
            end
            OP_PT_CHECK:
            begin
                scan_idx_next = '0;
                best_any_next = 1'b0;
                if (pt_valid_reg[page_reg])
                begin
                    frame_next   = pt_rdata.frame;
                    outcome_next = OUT_PT_HIT;
                end
                else
                begin
                    outcome_next = OUT_FAULT;
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_next = fault_cnt_reg + 1'b1;
                    end
                    if (!status.frames_full)
                    begin
                        frame_next         = frame_next_reg;
                        frame_next_next    = frame_next_reg + 1'b1;
                        frames_filled_next = frames_filled_reg + 1'b1;
                    end
                    else if (!lru_reg)
                    begin
                        frame_next      = frame_next_reg;
                        frame_next_next = frame_next_reg + 1'b1;
                    end
                end
            end
            OP_PT_SCAN:
            begin
                // Valid page with the oldest stamp, lowest page on ties.
                if (cmp_valid_reg && pt_valid_reg[cmp_pt_idx]
                    && (!best_any_reg || (pt_rdata.stamp < best_stamp_reg)))
                begin
                    best_any_next   = 1'b1;
                    best_stamp_next = pt_rdata.stamp;
                    best_frame_next = pt_rdata.frame;
                end
            end
            OP_LRU_PICK:
            begin
                if (best_any_reg)
                begin
                    frame_next = best_frame_reg;
                end
                else
                begin
                    frame_next      = frame_next_reg;
                    frame_next_next = frame_next_reg + 1'b1;
                end
            end
            OP_OWNER_READ:
            begin
                // The owner memory reads at the chosen frame.
            end
            OP_OWNER_PT_READ:
            begin
                owner_next = own_rdata;
                pt_raddr   = own_rdata;
            end
            OP_EVICT_CHECK:
            begin
                scan_idx_next = '0;
                // Without an eviction the free slot found by the lookup still holds.
                if (evict)
                begin
                    inv_found_next           = 1'b0;
                    ev_valid_next            = 1'b1;
                    ev_page_next             = owner_reg;
                    pt_valid_next[owner_reg] = 1'b0;
                end
            end
            OP_INV_SCAN:
            begin
                // Drop TLB entries of the evicted page and find the first free slot.
                if (cmp_valid_reg)
                begin
                    if (inv_match)
                    begin
                        tlb_valid_next[cmp_tlb_idx] = 1'b0;
                    end
                    if (!inv_found_reg && (!tlb_valid_reg[cmp_tlb_idx] || inv_match))
                    begin
                        inv_found_next = 1'b1;
                        inv_idx_next   = cmp_tlb_idx;
                    end
                end
            end
            OP_MISS_COMMIT:
            begin
                tlb_we               = 1'b1;
                tlb_waddr            = slot;
                tlb_wdata            = '{page: page_reg, frame: frame_reg, stamp: time_reg};
                tlb_valid_next[slot] = 1'b1;
                if ((tlb_filled_reg < TLB_CNT_W'(TLB_ENTRIES)) || !lru_reg)
                begin
                    tlb_next_next = tlb_next_reg + 1'b1;
                    if (tlb_filled_reg < TLB_CNT_W'(TLB_ENTRIES))
                    begin
                        tlb_filled_next = tlb_filled_reg + 1'b1;
                    end
                end
                pt_we                   = 1'b1;
                pt_valid_next[page_reg] = 1'b1;
                own_we                  = (outcome_reg == OUT_FAULT);
            end
            OP_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    o_page_next     = PAGE_FIELD_W'(page_reg);
                    o_frame_next    = FRAME_FIELD_W'(frame_reg);
                    o_pa_next       = PA_W'({frame_reg, offset_reg});
                    o_outcome_next  = outcome_reg;
                    o_ev_valid_next = ev_valid_reg;
                    o_ev_page_next  = PAGE_FIELD_W'(ev_page_reg);
                    o_hits_next     = hit_cnt_reg;
                    o_faults_next   = fault_cnt_reg;
                    time_next       = time_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg     <= '0;
            pt_valid_reg      <= '0;
            tlb_next_reg      <= '0;
            tlb_filled_reg    <= '0;
            frame_next_reg    <= '0;
            frames_filled_reg <= '0;
            time_reg          <= '0;
            hit_cnt_reg       <= '0;
            fault_cnt_reg     <= '0;
            lru_reg           <= 1'b0;
            scan_idx_reg      <= '0;
            cmp_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            tlb_valid_reg     <= tlb_valid_next;
            pt_valid_reg      <= pt_valid_next;
            tlb_next_reg      <= tlb_next_next;
            tlb_filled_reg    <= tlb_filled_next;
            frame_next_reg    <= frame_next_next;
            frames_filled_reg <= frames_filled_next;
            time_reg          <= time_next;
            hit_cnt_reg       <= hit_cnt_next;
            fault_cnt_reg     <= fault_cnt_next;
            lru_reg           <= lru_next;
            scan_idx_reg      <= scan_idx_next;
            cmp_valid_reg     <= cmp_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        page_reg       <= page_next;
        offset_reg     <= offset_next;
        frame_reg      <= frame_next;
        outcome_reg    <= outcome_next;
        ev_valid_reg   <= ev_valid_next;
        ev_page_reg    <= ev_page_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_frame_reg  <= hit_frame_next;
        min_stamp_reg  <= min_stamp_next;
        min_idx_reg    <= min_idx_next;
        inv_found_reg  <= inv_found_next;
        inv_idx_reg    <= inv_idx_next;
        best_any_reg   <= best_any_next;
        best_stamp_reg <= best_stamp_next;
        best_frame_reg <= best_frame_next;
        owner_reg      <= owner_next;
        o_page_reg     <= o_page_next;
        o_frame_reg    <= o_frame_next;
        o_pa_reg       <= o_pa_next;
        o_outcome_reg  <= o_outcome_next;
        o_ev_valid_reg <= o_ev_valid_next;
        o_ev_page_reg  <= o_ev_page_next;
        o_hits_reg     <= o_hits_next;
        o_faults_reg   <= o_faults_next;
    end

    // Result channel.
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.virt_page        = o_page_reg;
    assign out_ch.frame_number     = o_frame_reg;
    assign out_ch.physical_address = o_pa_reg;
    assign out_ch.outcome          = o_outcome_reg;
    assign out_ch.evicted_valid    = o_ev_valid_reg;
    assign out_ch.evicted_page     = o_ev_page_reg;
    assign out_ch.hit_total        = o_hits_reg;
    assign out_ch.fault_total      = o_faults_reg;

endmodule

[tb/tb_tlb_page_table_translator_core.sv]
// Self-checking testbench for the TLB and page table address translator.
`timescale 1ns / 1ps

module tb_tlb_page_table_translator_core;
    import tlbpt_pkg::*;

    // Expected translation of one virtual address.
    typedef struct packed {
        logic [7:0]  virt_page;
        logic [6:0]  frame_number;
        logic [14:0] physical_address;
        outcome_t    outcome;
        logic        evicted_valid;
        logic [7:0]  evicted_page;
        logic [31:0] hit_total;
        logic [31:0] fault_total;
    } translation_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    tlbpt_in_if  req_ch ();
    tlbpt_out_if rsp_ch ();

    tlb_page_table_translator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (req_ch.sink),
        .out_ch     (rsp_ch.source)
    );

    // Shadow state of the translator.
    logic        sh_tlb_valid [TLB_ENTRIES];
    logic [7:0]  sh_tlb_page  [TLB_ENTRIES];
    logic [6:0]  sh_tlb_frame [TLB_ENTRIES];
    logic [31:0] sh_tlb_stamp [TLB_ENTRIES];
    logic [4:0]  sh_tlb_next;
    int          sh_tlb_filled;
    logic        sh_pt_valid  [PAGE_COUNT];
    logic [6:0]  sh_pt_frame  [PAGE_COUNT];
    logic [31:0] sh_pt_stamp  [PAGE_COUNT];
    logic [7:0]  sh_owner     [FRAME_COUNT];
    logic [6:0]  sh_frame_next;
    int          sh_frames_filled;
    logic [31:0] sh_clock;
    logic [31:0] sh_hits;
    logic [31:0] sh_faults;
    logic        sh_lru;

    translation_t   expected_q[$];
    logic [15:0]    address_q[$];
    int             mismatches;
    int             results_seen;
    int             cycles;
    bit             hold_sender;
    int             req_gap;
    int             rsp_gap;

    // Places a page and frame into the shadow TLB.
    task automatic tlb_fill(input logic [7:0] page, input logic [6:0] frame,
                            input logic [31:0] stamp);
        int slot;
        bit found;
        slot = 0;
        found = 0;
        if (sh_tlb_filled < TLB_ENTRIES || !sh_lru) begin
            slot = sh_tlb_next;
            sh_tlb_next = sh_tlb_next + 1;
            if (sh_tlb_filled < TLB_ENTRIES)
                sh_tlb_filled++;
        end
        else begin
            for (int i = 0; i < TLB_ENTRIES && !found; i++)
                if (!sh_tlb_valid[i]) begin
                    slot = i;
                    found = 1;
                end
            if (!found)
                for (int i = 1; i < TLB_ENTRIES; i++)
                    if (sh_tlb_stamp[i] < sh_tlb_stamp[slot])
                        slot = i;
        end
        sh_tlb_valid[slot] = 1;
        sh_tlb_page[slot]  = page;
        sh_tlb_frame[slot] = frame;
        sh_tlb_stamp[slot] = stamp;
    endtask

    // Computes the translation of one address and advances the shadow state.
    task automatic translate(input logic [15:0] va, output translation_t r);
        logic [7:0]  page;
        logic [6:0]  frame;
        logic [7:0]  owner;
        logic [31:0] t;
        bit hit;
        bit any;
        int best;
        page  = va[15:8];
        t     = sh_clock;
        frame = 0;
        hit   = 0;
        r     = '0;
        for (int i = 0; i < TLB_ENTRIES && !hit; i++)
            if (sh_tlb_valid[i] && sh_tlb_page[i] == page) begin
                hit = 1;
                sh_tlb_stamp[i] = t;
                frame = sh_tlb_frame[i];
            end
        if (hit) begin
            sh_pt_stamp[page] = t;
            if (sh_hits != '1)
                sh_hits++;
            r.outcome = OUT_TLB_HIT;
        end
        else if (sh_pt_valid[page]) begin
            sh_pt_stamp[page] = t;
            frame = sh_pt_frame[page];
            tlb_fill(page, frame, t);
            r.outcome = OUT_PT_HIT;
        end
        else begin
            r.outcome = OUT_FAULT;
            if (sh_faults != '1)
                sh_faults++;
            if (sh_frames_filled < FRAME_COUNT) begin
                frame = sh_frame_next++;
                sh_frames_filled++;
            end
            else begin
                any  = 0;
                best = 0;
                if (sh_lru)
                    for (int i = 0; i < PAGE_COUNT; i++)
                        if (sh_pt_valid[i] && (!any || sh_pt_stamp[i] < sh_pt_stamp[best])) begin
                            best = i;
                            any  = 1;
                        end
                if (any)
                    frame = sh_pt_frame[best];
                else
                    frame = sh_frame_next++;
                // The old owner is evicted only if its mapping still points here.
                owner = sh_owner[frame];
                if (sh_pt_valid[owner] && sh_pt_frame[owner] == frame) begin
                    r.evicted_valid = 1;
                    r.evicted_page  = owner;
                    sh_pt_valid[owner] = 0;
                    sh_pt_stamp[owner] = 0;
                    for (int i = 0; i < TLB_ENTRIES; i++)
                        if (sh_tlb_valid[i] && sh_tlb_page[i] == owner)
                            sh_tlb_valid[i] = 0;
                end
            end
            tlb_fill(page, frame, t);
            sh_pt_frame[page] = frame;
            sh_pt_valid[page] = 1;
            sh_pt_stamp[page] = t;
            sh_owner[frame]   = page;
        end
        sh_clock = sh_clock + 1;
        r.virt_page        = page;
        r.frame_number     = frame;
        r.physical_address = {frame, va[7:0]};
        r.hit_total        = sh_hits;
        r.fault_total      = sh_faults;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Clock.
    initial clk = 0;
    always #5 clk = ~clk;

    // Cycle counter and timeout.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver: feeds queued addresses and predicts each accepted transaction.
    always @(posedge clk or negedge rst_n) begin
        translation_t r;
        if (!rst_n) begin
            req_ch.valid           <= 0;
            req_ch.virtual_address <= '0;
            req_gap                <= 0;
        end
        else begin
            if (req_ch.valid && req_ch.ready) begin
                translate(req_ch.virtual_address, r);
                expected_q.push_back(r);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap > 0 || hold_sender || address_q.size() == 0) begin
                    req_ch.valid <= 0;
                    if (req_gap > 0)
                        req_gap <= req_gap - 1;
                end
                else begin
                    req_ch.valid           <= 1;
                    req_ch.virtual_address <= address_q.pop_front();
                    req_gap                <= pick_gap();
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk or negedge rst_n) begin
        translation_t want;
        translation_t got;
        if (!rst_n) begin
            rsp_ch.ready <= 0;
            rsp_gap      <= 0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.virt_page        = rsp_ch.virt_page;
                got.frame_number     = rsp_ch.frame_number;
                got.physical_address = rsp_ch.physical_address;
                got.outcome          = outcome_t'(rsp_ch.outcome);
                got.evicted_valid    = rsp_ch.evicted_valid;
                got.evicted_page     = rsp_ch.evicted_page;
                got.hit_total        = rsp_ch.hit_total;
                got.fault_total      = rsp_ch.fault_total;
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected transaction: %p", got);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                                     results_seen, want, got);
                    end
                end
            end
            if (rsp_gap > 0) begin
                rsp_ch.ready <= 0;
                rsp_gap      <= rsp_gap - 1;
            end
            else begin
                rsp_ch.ready <= 1;
                rsp_gap      <= pick_gap();
            end
        end
    end

    // Waits until every predicted result has been checked; sampled at the falling
    // edge so that the driver's updates of the rising edge have settled.
    task automatic drain();
        @(negedge clk);
        while (address_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Switches the replacement policy while the block is idle.
    task automatic set_policy(input logic lru);
        cfg_wr_en   <= 1;
        cfg_wr_data <= lru;
        @(posedge clk);
        cfg_wr_en   <= 0;
        sh_lru = lru;
    endtask

    // Queues a phase of accesses: a working set with reuse, plus stray pages.
    task automatic queue_phase(input int count, input int span);
        int base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 9) < 8)
                address_q.push_back({8'(base + $urandom_range(0, span - 1)),
                                     8'($urandom)});
            else
                address_q.push_back(16'($urandom));
    endtask

    initial begin
        int lru_phases;
        mismatches       = 0;
        results_seen     = 0;
        cycles           = 0;
        hold_sender      = 0;
        cfg_wr_en        = 0;
        cfg_wr_data      = 0;
        sh_tlb_next      = 0;
        sh_tlb_filled    = 0;
        sh_frame_next    = 0;
        sh_frames_filled = 0;
        sh_clock         = 0;
        sh_hits          = 0;
        sh_faults        = 0;
        sh_lru           = 0;
        lru_phases       = 0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            sh_tlb_valid[i] = 0;
            sh_tlb_stamp[i] = 0;
        end
        for (int i = 0; i < PAGE_COUNT; i++) begin
            sh_pt_valid[i] = 0;
            sh_pt_stamp[i] = 0;
        end
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed: address extremes, repeat hits, and a late TLB hit on page zero.
        address_q.push_back(16'h0000);
        address_q.push_back(16'hFFFF);
        address_q.push_back(16'h00FF);
        address_q.push_back(16'hFF00);
        address_q.push_back(16'hAA55);
        address_q.push_back(16'h55AA);
        for (int i = 1; i <= 16; i++)
            address_q.push_back({8'(i), 8'(i * 7)});
        address_q.push_back(16'h0011);
        // Pressure: wait for all results, then hold and release the sender.
        drain();
        hold_sender = 1;
        repeat (20) @(posedge clk);
        hold_sender = 0;

        // Fill every frame in FIFO mode so evictions start.
        for (int i = 0; i < 140; i++)
            address_q.push_back({8'(i + 20), 8'($urandom)});
        drain();

        // Alternate policies with random working sets.
        for (int ph = 0; ph < 6; ph++) begin
            set_policy(ph % 2 == 0);
            if (ph % 2 == 0)
                lru_phases++;
            queue_phase(ph % 2 == 0 ? 50 : 80, ph < 3 ? 40 : 180);
            drain();
        end
        set_policy(0);
        queue_phase(40, 256);
        drain();

        $display("checked %0d translations over FIFO and LRU policies (%0d LRU phases),",
                 results_seen, lru_phases);
        $display("hits %0d, faults %0d, mismatches %0d", sh_hits, sh_faults, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
